[sv/led_matrix_bcm_scan_driver_unit_defines.svh]
// Assertion macros shared by the scan driver RTL.
`ifndef LED_MATRIX_BCM_SCAN_DRIVER_UNIT_DEFINES_SVH
`define LED_MATRIX_BCM_SCAN_DRIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMBSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LMBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lmbsd_pkg.sv]
// Types and constants of the LED matrix scan driver.
package lmbsd_pkg;

  // Command codes of an input beat
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FLIP  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // Brightness register
  localparam int unsigned BRIGHT_W     = 5;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd10;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MIN   = 5'd2;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 5'd30;

  // Field widths of the beats
  localparam int unsigned ROW_IN_W = 3;
  localparam int unsigned COL_IN_W = 5;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned LS_W     = 3;
  localparam int unsigned PLANE_W  = 3;
  localparam int unsigned BIT_W    = 3;

  // Output queue
  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned FIFO_PTR_W = 2;

  typedef struct packed {
    cmd_t                command;
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] column;
    logic [CODE_W-1:0]   red;
    logic [CODE_W-1:0]   green;
    logic [CODE_W-1:0]   blue;
  } in_beat_t;

  typedef struct packed {
    logic               red_bit;
    logic               green_bit;
    logic               blue_bit;
    logic [LS_W-1:0]    line_select;
    logic               latch;
    logic               blank;
    logic [PLANE_W-1:0] plane;
  } out_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
  } pix_t;

  localparam int unsigned PIX_W = $bits(pix_t);

endpackage

[sv/lmbsd_stream_if.sv]
// Valid/ready stream interface carrying one beat of type T.
interface lmbsd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/led_matrix_bcm_scan_driver_unit.sv]
// Binary code modulation scan driver for a double-banked RGB LED matrix half.
// An accepted tick passes the word stage and then the output queue before it is offered.
// Throughput: one beat per cycle while ready is high; the pixel memory read register and a
// three-entry output queue carry ticks back to back and absorb sink stalls.
// Reset: control state clears, brightness returns to 10, then a clearing pass zeroes all
// 2^(1+clog2(ROWS)+clog2(COLUMNS)) pixel memory entries (512 by default) with ready low.
module led_matrix_bcm_scan_driver_unit #(
  parameter int unsigned PLANES  = 7,
  parameter int unsigned ROWS    = 8,
  parameter int unsigned COLUMNS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lmbsd_stream_if.sink                      in_ch,
  lmbsd_stream_if.source                    out_ch,
  input  logic                              cfg_we,
  input  logic [lmbsd_pkg::BRIGHT_W-1:0]    cfg_wdata
);
  import lmbsd_pkg::*;

  `include "led_matrix_bcm_scan_driver_unit_defines.svh"

  localparam int unsigned ROW_W   = $clog2(ROWS);
  localparam int unsigned COL_W   = $clog2(COLUMNS);
  localparam int unsigned ADDR_W  = 1 + ROW_W + COL_W;
  localparam int unsigned PL_W    = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int unsigned CNT_W   = PLANES + 1;
  localparam int unsigned SLOT_W  = PLANES;
  localparam int unsigned SLOTS   = (2 ** PLANES) - 1;
  localparam int unsigned RX_W    = (ROW_W > LS_W) ? ROW_W : LS_W;
  localparam int unsigned CX_W    = (COL_W > BRIGHT_W) ? COL_W : BRIGHT_W;
  localparam int unsigned BIT_OFS = 8 - PLANES;

  // Control and configuration state
  logic                 clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [BRIGHT_W-1:0]  bright_r, bright_nxt;
  logic                 back_sel_r, back_sel_nxt;
  logic [ROW_W-1:0]     row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]     col_cnt_r, col_cnt_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [PL_W-1:0]      cur_plane_r, cur_plane_nxt;
  logic [CNT_W-1:0]     cnt_r   [PLANES];
  logic [CNT_W-1:0]     cnt_nxt [PLANES];

  // Word stage waiting on the pixel read
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_zero_r, s1_zero_nxt;
  logic [BIT_W-1:0]     s1_bit_r, s1_bit_nxt;
  logic [LS_W-1:0]      s1_ls_r, s1_ls_nxt;
  logic                 s1_latch_r, s1_latch_nxt;
  logic                 s1_blank_r, s1_blank_nxt;
  logic [PLANE_W-1:0]   s1_plane_r, s1_plane_nxt;

  // Memory port signals
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  pix_t                 ram_wdata, ram_rdata;

  // Plane choice
  logic [CNT_W-1:0]     base [PLANES];
  logic [CNT_W-1:0]     cnt_upd [PLANES];
  logic [PL_W-1:0]      pick;
  logic [PL_W-1:0]      plane_now;

  // Column swizzle
  logic [COL_W-1:0]     x_col;
  logic [CX_W-1:0]      x_ext;
  logic                 x_inside;
  logic [COL_W-1:0]     pix_col;
  logic                 word_first;
  logic                 word_last;

  logic                 acc;
  logic                 tick_acc;
  logic                 frame_end;
  logic                 plane_ok;
  logic [FIFO_PTR_W-1:0] fifo_level;
  logic                 has_room;
  out_beat_t            word_s1;

  // Ready while no clearing pass runs and the queue has room for a beat in flight
  assign has_room = (fifo_level == '0)
                 || (fifo_level == FIFO_PTR_W'(1))
                 || ((fifo_level == FIFO_PTR_W'(2)) && !s1_valid_r);
  assign in_ch.ready = !clr_active_r && has_room;
  assign acc         = in_ch.valid && in_ch.ready;
  assign tick_acc    = acc && (in_ch.data.command == CMD_TICK);

  assign word_first = (row_cnt_r == '0) && (col_cnt_r == '0);
  assign word_last  = (row_cnt_r == ROW_W'(ROWS - 1)) && (col_cnt_r == COL_W'(COLUMNS - 1));
  assign frame_end  = word_last && (slot_r == SLOT_W'(SLOTS - 1));

  // Pick the plane with the smallest weighted count, higher plane on a tie
  always_comb begin
    for (int j = 0; j < PLANES; j++) begin
      base[j] = (slot_r == '0) ? '0 : cnt_r[j];
    end
    pick = '0;
    for (int j = 0; j < PLANES; j++) begin
      if (base[j] <= base[pick]) begin
        pick = PL_W'(j);
      end
    end
    for (int j = 0; j < PLANES; j++) begin
      cnt_upd[j] = base[j] + ((PL_W'(j) == pick) ? (CNT_W'(1) << (PLANES - j)) : '0);
    end
  end

  assign plane_now = word_first ? pick : cur_plane_r;

  // Swizzle the column and derive its line controls
  assign x_col    = col_cnt_r ^ COL_W'(2);
  assign x_ext    = CX_W'(x_col);
  assign x_inside = ({1'b0, x_col} < (COL_W + 1)'(COLUMNS));
  assign pix_col  = COL_W'(COLUMNS - 1) - x_col;

  // Next state for every command
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    bright_nxt     = bright_r;
    back_sel_nxt   = back_sel_r;
    row_cnt_nxt    = row_cnt_r;
    col_cnt_nxt    = col_cnt_r;
    slot_nxt       = slot_r;
    cur_plane_nxt  = cur_plane_r;
    for (int j = 0; j < PLANES; j++) begin
      cnt_nxt[j] = cnt_r[j];
    end
    s1_valid_nxt = 1'b0;
    s1_zero_nxt  = s1_zero_r;
    s1_bit_nxt   = s1_bit_r;
    s1_ls_nxt    = s1_ls_r;
    s1_latch_nxt = s1_latch_r;
    s1_blank_nxt = s1_blank_r;
    s1_plane_nxt = s1_plane_r;
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = {~back_sel_r, row_cnt_r, pix_col};

    // Clamp brightness writes
    if (cfg_we) begin
      if (cfg_wdata < BRIGHT_MIN) begin
        bright_nxt = BRIGHT_MIN;
      end else if (cfg_wdata > BRIGHT_MAX) begin
        bright_nxt = BRIGHT_MAX;
      end else begin
        bright_nxt = cfg_wdata;
      end
    end

    // Sweep zeros through the pixel memory after reset
    if (clr_active_r) begin
      ram_we         = 1'b1;
      clr_addr_nxt   = clr_addr_r + ADDR_W'(1);
      clr_active_nxt = !(&clr_addr_r);
    end

    if (acc) begin
      unique case (in_ch.data.command)
        CMD_WRITE: begin
          if ((6'(in_ch.data.row) < 6'(ROWS)) && (8'(in_ch.data.column) < 8'(COLUMNS))) begin
            ram_we    = 1'b1;
            ram_waddr = {back_sel_r, ROW_W'(in_ch.data.row), COL_W'(in_ch.data.column)};
            ram_wdata = '{red: in_ch.data.red, green: in_ch.data.green,
                          blue: in_ch.data.blue};
          end
        end
        CMD_FLIP: begin
          back_sel_nxt = ~back_sel_r;
        end
        CMD_TICK: begin
          // Start of slot: commit the chosen plane
          if (word_first) begin
            cur_plane_nxt = pick;
            for (int j = 0; j < PLANES; j++) begin
              cnt_nxt[j] = cnt_upd[j];
            end
          end
          // Advance column, row and slot
          if (col_cnt_r == COL_W'(COLUMNS - 1)) begin
            col_cnt_nxt = '0;
            if (row_cnt_r == ROW_W'(ROWS - 1)) begin
              row_cnt_nxt = '0;
              slot_nxt    = (slot_r == SLOT_W'(SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
            end else begin
              row_cnt_nxt = row_cnt_r + ROW_W'(1);
            end
          end else begin
            col_cnt_nxt = col_cnt_r + COL_W'(1);
          end
          // Issue the pixel read and stage the line controls
          ram_re       = 1'b1;
          s1_valid_nxt = 1'b1;
          s1_zero_nxt  = !x_inside;
          s1_bit_nxt   = BIT_W'(BIT_OFS) + BIT_W'(plane_now);
          s1_ls_nxt    = LS_W'(RX_W'(row_cnt_r) - RX_W'(1));
          s1_latch_nxt = (x_col == COL_W'(COLUMNS - 1));
          s1_blank_nxt = (x_col < COL_W'(2)) || (x_ext >= CX_W'(bright_r));
          s1_plane_nxt = PLANE_W'(plane_now);
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      bright_r     <= BRIGHT_RESET;
      back_sel_r   <= 1'b0;
      row_cnt_r    <= '0;
      col_cnt_r    <= '0;
      slot_r       <= '0;
      cur_plane_r  <= '0;
      s1_valid_r   <= 1'b0;
      for (int j = 0; j < PLANES; j++) begin
        cnt_r[j] <= '0;
      end
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      bright_r     <= bright_nxt;
      back_sel_r   <= back_sel_nxt;
      row_cnt_r    <= row_cnt_nxt;
      col_cnt_r    <= col_cnt_nxt;
      slot_r       <= slot_nxt;
      cur_plane_r  <= cur_plane_nxt;
      s1_valid_r   <= s1_valid_nxt;
      for (int j = 0; j < PLANES; j++) begin
        cnt_r[j] <= cnt_nxt[j];
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    s1_zero_r  <= s1_zero_nxt;
    s1_bit_r   <= s1_bit_nxt;
    s1_ls_r    <= s1_ls_nxt;
    s1_latch_r <= s1_latch_nxt;
    s1_blank_r <= s1_blank_nxt;
    s1_plane_r <= s1_plane_nxt;
  end

  lmbsd_pix_ram #(
    .ADDR_W (ADDR_W)
  ) u_pix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Test the selected plane bit of each channel
  always_comb begin
    word_s1.red_bit     = !s1_zero_r && ram_rdata.red[s1_bit_r];
    word_s1.green_bit   = !s1_zero_r && ram_rdata.green[s1_bit_r];
    word_s1.blue_bit    = !s1_zero_r && ram_rdata.blue[s1_bit_r];
    word_s1.line_select = s1_ls_r;
    word_s1.latch       = s1_latch_r;
    word_s1.blank       = s1_blank_r;
    word_s1.plane       = s1_plane_r;
  end

  lmbsd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (word_s1),
    .out_ch    (out_ch),
    .level     (fifo_level)
  );

  assign plane_ok = ({1'b0, s1_plane_r} < (PLANE_W + 1)'(PLANES));

  `LMBSD_ASSERT_IMPL(a_no_beat_while_clearing, clk, rst_n, clr_active_r, !in_ch.ready, "beat accepted during clearing pass")
  `LMBSD_ASSERT_NEXT(a_tick_fills_stage, clk, rst_n, tick_acc, s1_valid_r, "tick did not reach the word stage")
  `LMBSD_ASSERT_IMPL(a_queue_has_room, clk, rst_n, s1_valid_r, fifo_level < FIFO_PTR_W'(FIFO_DEPTH), "output queue overflow")
  `LMBSD_ASSERT_IMPL(a_plane_in_range, clk, rst_n, s1_valid_r, plane_ok, "played plane out of range")
  `LMBSD_ASSERT_NEXT(a_frame_wraps, clk, rst_n, tick_acc && frame_end, (slot_r == '0) && word_first, "frame did not wrap to slot zero")
endmodule

[sv/lmbsd_pix_ram.sv]
// Pixel bank memory: one write port, one read port, registered read data.
module lmbsd_pix_ram #(
  parameter int unsigned ADDR_W = 9
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  lmbsd_pkg::pix_t            wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output lmbsd_pkg::pix_t            rdata
);
  import lmbsd_pkg::*;

  pix_t mem_r [2**ADDR_W];
  pix_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[sv/lmbsd_out_fifo.sv]
// Three-entry output queue that decouples result beats from the sink.
module lmbsd_out_fifo (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  lmbsd_pkg::out_beat_t                 push_data,
  lmbsd_stream_if.source                       out_ch,
  output logic [lmbsd_pkg::FIFO_PTR_W-1:0]     level
);
  import lmbsd_pkg::*;

  out_beat_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W-1:0] level_r, level_nxt;
  logic                  pop;

  assign pop = out_ch.valid && out_ch.ready;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                   : wr_ptr_r + FIFO_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                   : rd_ptr_r + FIFO_PTR_W'(1);
    end
    if (push && !pop) begin
      level_nxt = level_r + FIFO_PTR_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - FIFO_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Store beats
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_ch.valid = (level_r != '0);
  assign out_ch.data  = mem_r[rd_ptr_r];
  assign level        = level_r;
endmodule
